### src/hrs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heightmap resample/smooth block.
// No dependencies; every other file but hrs_ram.sv refers to this package by scoped names.
package hrs_pkg;

	// Sizing defaults
	localparam int MAX_SRC_SIDE = 256;
	localparam int OUT_WIDTH    = 128;
	localparam int OUT_HEIGHT   = 128;

	// Field widths
	localparam int OUT_COL_W   = (OUT_WIDTH > 2) ? $clog2(OUT_WIDTH) : 1;
	localparam int OUT_ROW_W   = (OUT_HEIGHT > 2) ? $clog2(OUT_HEIGHT) : 1;
	localparam int ADDR_W      = 16;
	localparam int STORE_DEPTH = 65536;
	localparam int SAMPLE_W    = 8;
	localparam int STEP_W      = 24;
	localparam int CFG_SIDE_W  = 9;
	localparam int FRAC_W      = 16;
	localparam int NUM_TAPS    = 5;
	localparam int TAPS_W      = 3;
	localparam int AVG_SUM_W   = 11;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = CFG_IDX_W'(3);

	// Register reset values (steps are 2.0 in Q8.16)
	localparam logic [CFG_SIDE_W-1:0] RST_SRC_WIDTH  = CFG_SIDE_W'(256);
	localparam logic [CFG_SIDE_W-1:0] RST_SRC_HEIGHT = CFG_SIDE_W'(256);
	localparam logic [STEP_W-1:0]     RST_X_STEP     = STEP_W'(131072);
	localparam logic [STEP_W-1:0]     RST_Y_STEP     = STEP_W'(131072);

	// Command codes
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// Tap slots: center, up, down, left, right
	localparam int TAP_C = 0;
	localparam int TAP_U = 1;
	localparam int TAP_D = 2;
	localparam int TAP_L = 3;
	localparam int TAP_R = 4;

	typedef logic [ADDR_W-1:0]   addr_t;
	typedef logic [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		logic                 action;
		logic [ADDR_W-1:0]    src_index;
		logic [SAMPLE_W-1:0]  sample;
		logic [OUT_COL_W-1:0] out_col;
		logic [OUT_ROW_W-1:0] out_row;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] height_avg;
		logic [TAPS_W-1:0]   taps_used;
	} out_item_t;

	// Query beat leaving address generation, with its tap enables
	typedef struct packed {
		logic valid;
		logic use_up;
		logic use_dn;
		logic use_lf;
		logic use_rt;
	} tap_ctl_t;

	// Sample write shared by all tap memories
	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] data;
	} ram_wr_t;

endpackage

### src/heightmap_resample_smooth.sv
`timescale 1ns / 1ps
// Top level of the heightmap resample/smooth block: config, address pipeline,
// five tap memories and averaging. Depends on hrs_pkg, hrs_cfg, hrs_addr, hrs_ram, hrs_avg.
//
// One command beat is taken every clock (busy is high only in the first cycle out of
// reset). A load writes one sample and returns nothing; a query returns its result on
// result with done high for one cycle, in command order. The result cannot be held
// off. The rate is set by the sample store, which is kept as five identical 64K x 8
// memories, one per tap, all written by every load, so that the five reads of a query
// happen in one cycle. Loads write in the same pipeline stage where queries read, so
// each query sees exactly the loads that came before it. Configuration is taken at any
// time (cfg_ready stays high) but must only change while no query is in flight.
module heightmap_resample_smooth #(
	parameter int MAX_SRC_SIDE = hrs_pkg::MAX_SRC_SIDE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  hrs_pkg::in_item_t              item,
	output logic                           done,
	output hrs_pkg::out_item_t             result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrs_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int SIDE_W    = $clog2(MAX_SRC_SIDE + 1);
	localparam int LATENCY   = 8;
	localparam int WR_STAGE  = 5;

	logic                                     busy_q;
	logic                                     accept;
	logic [SIDE_W-1:0]                        src_w, src_h;
	logic [hrs_pkg::STEP_W-1:0]               x_step, y_step;
	hrs_pkg::tap_ctl_t                        ctl;
	hrs_pkg::addr_t   [hrs_pkg::NUM_TAPS-1:0] raddr;
	hrs_pkg::sample_t [hrs_pkg::NUM_TAPS-1:0] rdata;
	hrs_pkg::ram_wr_t                         wr;

	// Held busy through reset; the pipeline itself never stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy   = busy_q;
	assign accept = start & ~busy_q;

	hrs_cfg #(.MAX_SRC_SIDE(MAX_SRC_SIDE)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src_w     (src_w),
		.src_h     (src_h),
		.x_step    (x_step),
		.y_step    (y_step)
	);

	hrs_addr #(.MAX_SRC_SIDE(MAX_SRC_SIDE)) u_addr (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.in_item  (item),
		.src_w    (src_w),
		.src_h    (src_h),
		.x_step   (x_step),
		.y_step   (y_step),
		.ctl      (ctl),
		.raddr    (raddr),
		.wr       (wr)
	);

	// One sample memory per tap
	for (genvar g = 0; g < hrs_pkg::NUM_TAPS; g++) begin : g_tap_ram
		hrs_ram #(
			.WIDTH (hrs_pkg::SAMPLE_W),
			.DEPTH (hrs_pkg::STORE_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (wr.en),
			.waddr (wr.addr),
			.wdata (wr.data),
			.raddr (raddr[g]),
			.rdata (rdata[g])
		);
	end

	hrs_avg u_avg (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rdata  (rdata),
		.done   (done),
		.result (result)
	);

	// Every result traces back to a query taken a fixed latency earlier
	a_done_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && item.action == hrs_pkg::ACT_QUERY, LATENCY))
		else $error("result without a matching query");

	// Store writes come only from loads, at the read stage
	a_write_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> $past(accept && item.action == hrs_pkg::ACT_LOAD, WR_STAGE))
		else $error("sample write without a matching load");

	// Tap count stays within one to five
	a_taps_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.taps_used != '0 && result.taps_used <= hrs_pkg::TAPS_W'(5)))
		else $error("tap count out of range");

endmodule

### src/hrs_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module hrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536,
	localparam int AW = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### src/hrs_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and saturated source dimensions.
// Depends on hrs_pkg.
module hrs_cfg #(
	parameter int MAX_SRC_SIDE = hrs_pkg::MAX_SRC_SIDE,
	localparam int SIDE_W = $clog2(MAX_SRC_SIDE + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [hrs_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hrs_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [SIDE_W-1:0]              src_w,
	output logic [SIDE_W-1:0]              src_h,
	output logic [hrs_pkg::STEP_W-1:0]     x_step,
	output logic [hrs_pkg::STEP_W-1:0]     y_step
);

	localparam int CMP_W = (hrs_pkg::CFG_SIDE_W > SIDE_W) ? hrs_pkg::CFG_SIDE_W + 1 : SIDE_W + 1;

	logic [hrs_pkg::CFG_SIDE_W-1:0] src_width_q;
	logic [hrs_pkg::CFG_SIDE_W-1:0] src_height_q;
	logic [hrs_pkg::STEP_W-1:0]     x_step_q;
	logic [hrs_pkg::STEP_W-1:0]     y_step_q;

	// Clamp a programmed side to [2, MAX_SRC_SIDE]
	function automatic logic [SIDE_W-1:0] sat_side(input logic [hrs_pkg::CFG_SIDE_W-1:0] v);
		logic [CMP_W-1:0]  e;
		logic [SIDE_W-1:0] r;
		e = CMP_W'(v);
		if (e < CMP_W'(2)) begin
			r = SIDE_W'(2);
		end else if (e > CMP_W'(MAX_SRC_SIDE)) begin
			r = SIDE_W'(MAX_SRC_SIDE);
		end else begin
			r = SIDE_W'(e);
		end
		return r;
	endfunction

	// Register writes; always ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= hrs_pkg::RST_SRC_WIDTH;
			src_height_q <= hrs_pkg::RST_SRC_HEIGHT;
			x_step_q     <= hrs_pkg::RST_X_STEP;
			y_step_q     <= hrs_pkg::RST_Y_STEP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				hrs_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data[hrs_pkg::CFG_SIDE_W-1:0];
				hrs_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data[hrs_pkg::CFG_SIDE_W-1:0];
				hrs_pkg::REG_X_STEP:     x_step_q     <= cfg_data[hrs_pkg::STEP_W-1:0];
				hrs_pkg::REG_Y_STEP:     y_step_q     <= cfg_data[hrs_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign src_w     = sat_side(src_width_q);
	assign src_h     = sat_side(src_height_q);
	assign x_step    = x_step_q;
	assign y_step    = y_step_q;

endmodule

### src/hrs_addr.sv
`timescale 1ns / 1ps
// Address generation pipeline: position, tap tests, clamping and the five
// sample addresses; loads ride along and write at the read stage. Depends on hrs_pkg.
module hrs_addr #(
	parameter int MAX_SRC_SIDE = hrs_pkg::MAX_SRC_SIDE,
	localparam int SIDE_W = $clog2(MAX_SRC_SIDE + 1)
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        in_valid,
	input  hrs_pkg::in_item_t                           in_item,
	input  logic [SIDE_W-1:0]                           src_w,
	input  logic [SIDE_W-1:0]                           src_h,
	input  logic [hrs_pkg::STEP_W-1:0]                  x_step,
	input  logic [hrs_pkg::STEP_W-1:0]                  y_step,
	output hrs_pkg::tap_ctl_t                           ctl,
	output hrs_pkg::addr_t [hrs_pkg::NUM_TAPS-1:0]      raddr,
	output hrs_pkg::ram_wr_t                            wr
);

	localparam int FW     = hrs_pkg::FRAC_W;
	localparam int IDX_W  = (MAX_SRC_SIDE > 2) ? $clog2(MAX_SRC_SIDE) : 1;
	localparam int YR_W   = hrs_pkg::OUT_ROW_W + hrs_pkg::STEP_W;
	localparam int XP_W   = hrs_pkg::OUT_COL_W + hrs_pkg::STEP_W;
	localparam int MP_W   = (YR_W > XP_W) ? YR_W : XP_W;
	localparam int POS_W  = ((MP_W > SIDE_W + FW) ? MP_W : SIDE_W + FW) + 2;
	localparam int IP_W   = POS_W - FW;
	localparam int PROD_W = IDX_W + SIDE_W;
	localparam int ASUM_W = ((PROD_W > hrs_pkg::ADDR_W) ? PROD_W : hrs_pkg::ADDR_W) + 1;

	localparam logic [POS_W-1:0] Q_ONE  = POS_W'(1) << FW;
	localparam logic [POS_W-1:0] Q_HALF = POS_W'(1) << (FW - 1);

	// Q position (two's complement) to a row/column index clamped to [0, n-1]
	function automatic logic [IDX_W-1:0] clamp_idx(input logic [POS_W-1:0] v,
		input logic [SIDE_W-1:0] n);
		logic [IP_W-1:0]  ip;
		logic [IDX_W-1:0] r;
		ip = v[POS_W-1:FW];
		if (v[POS_W-1]) begin
			r = '0;
		end else if (ip >= IP_W'(n)) begin
			r = IDX_W'(n - SIDE_W'(1));
		end else begin
			r = ip[IDX_W-1:0];
		end
		return r;
	endfunction

	// Row base plus column, wrapped to the store depth
	function automatic hrs_pkg::addr_t addr_of(input logic [PROD_W-1:0] base,
		input logic [IDX_W-1:0] col);
		logic [ASUM_W-1:0] s;
		s = ASUM_W'(base) + ASUM_W'(col);
		return s[hrs_pkg::ADDR_W-1:0];
	endfunction

	// Stage 1: captured beat
	logic              vld_s1;
	hrs_pkg::in_item_t item_s1;

	// Stage 2: products
	logic             vld_s2, qry_s2;
	hrs_pkg::addr_t   idx_s2;
	hrs_pkg::sample_t smp_s2;
	logic [YR_W-1:0]  yr_s2;
	logic [XP_W-1:0]  xp_s2;

	// Stage 3: source position
	logic             vld_s3, qry_s3;
	hrs_pkg::addr_t   idx_s3;
	hrs_pkg::sample_t smp_s3;
	logic [POS_W-1:0] yr_s3;
	logic [POS_W-1:0] xr_s3;

	// Stage 4: tap tests and clamped indices
	logic             vld_s4, qry_s4;
	hrs_pkg::addr_t   idx_s4;
	hrs_pkg::sample_t smp_s4;
	logic             up_s4, dn_s4, lf_s4, rt_s4;
	logic [IDX_W-1:0] rc_s4, ru_s4, rd_s4;
	logic [IDX_W-1:0] cc_s4, cl_s4, cr_s4;

	// Stage 5: row bases, memory access
	logic              vld_s5, qry_s5;
	hrs_pkg::addr_t    idx_s5;
	hrs_pkg::sample_t  smp_s5;
	logic              up_s5, dn_s5, lf_s5, rt_s5;
	logic [PROD_W-1:0] bc_s5, bu_s5, bd_s5;
	logic [IDX_W-1:0]  cc_s5, cl_s5, cr_s5;

	logic [POS_W-1:0] hm2_q, wm2_q;

	assign hm2_q = POS_W'({SIDE_W'(src_h - SIDE_W'(2)), FW'(0)});
	assign wm2_q = POS_W'({SIDE_W'(src_w - SIDE_W'(2)), FW'(0)});

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		item_s1 <= in_item;

		qry_s2 <= (item_s1.action == hrs_pkg::ACT_QUERY);
		idx_s2 <= item_s1.src_index;
		smp_s2 <= item_s1.sample;
		yr_s2  <= YR_W'(item_s1.out_row) * YR_W'(y_step);
		xp_s2  <= XP_W'(item_s1.out_col) * XP_W'(x_step);

		qry_s3 <= qry_s2;
		idx_s3 <= idx_s2;
		smp_s3 <= smp_s2;
		yr_s3  <= POS_W'(yr_s2);
		xr_s3  <= POS_W'({src_w, FW'(0)}) - POS_W'(xp_s2);

		qry_s4 <= qry_s3;
		idx_s4 <= idx_s3;
		smp_s4 <= smp_s3;
		up_s4  <= $signed(yr_s3) >= $signed(Q_ONE);
		dn_s4  <= $signed(yr_s3) <= $signed(hm2_q);
		lf_s4  <= $signed(xr_s3) >= $signed(Q_ONE);
		rt_s4  <= $signed(xr_s3) <= $signed(wm2_q);
		rc_s4  <= clamp_idx(yr_s3, src_h);
		ru_s4  <= clamp_idx(yr_s3 - Q_HALF, src_h);
		rd_s4  <= clamp_idx(yr_s3 + Q_HALF, src_h);
		cc_s4  <= clamp_idx(xr_s3, src_w);
		cl_s4  <= clamp_idx(xr_s3 - Q_HALF, src_w);
		cr_s4  <= clamp_idx(xr_s3 + Q_HALF, src_w);

		qry_s5 <= qry_s4;
		idx_s5 <= idx_s4;
		smp_s5 <= smp_s4;
		up_s5  <= up_s4;
		dn_s5  <= dn_s4;
		lf_s5  <= lf_s4;
		rt_s5  <= rt_s4;
		bc_s5  <= PROD_W'(rc_s4) * PROD_W'(src_w);
		bu_s5  <= PROD_W'(ru_s4) * PROD_W'(src_w);
		bd_s5  <= PROD_W'(rd_s4) * PROD_W'(src_w);
		cc_s5  <= cc_s4;
		cl_s5  <= cl_s4;
		cr_s5  <= cr_s4;
	end

	// Tap addresses: up/down share the center column, left/right the center row
	assign raddr[hrs_pkg::TAP_C] = addr_of(bc_s5, cc_s5);
	assign raddr[hrs_pkg::TAP_U] = addr_of(bu_s5, cc_s5);
	assign raddr[hrs_pkg::TAP_D] = addr_of(bd_s5, cc_s5);
	assign raddr[hrs_pkg::TAP_L] = addr_of(bc_s5, cl_s5);
	assign raddr[hrs_pkg::TAP_R] = addr_of(bc_s5, cr_s5);

	assign ctl.valid  = vld_s5 & qry_s5;
	assign ctl.use_up = up_s5;
	assign ctl.use_dn = dn_s5;
	assign ctl.use_lf = lf_s5;
	assign ctl.use_rt = rt_s5;

	// Loads write in the same stage that queries read, keeping beat order
	assign wr.en   = vld_s5 & ~qry_s5;
	assign wr.addr = idx_s5;
	assign wr.data = smp_s5;

endmodule

### src/hrs_avg.sv
`timescale 1ns / 1ps
// Tap summation and division by the tap count, then the result register.
// Depends on hrs_pkg.
module hrs_avg (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  hrs_pkg::tap_ctl_t                          ctl,
	input  hrs_pkg::sample_t [hrs_pkg::NUM_TAPS-1:0]   rdata,
	output logic                                       done,
	output hrs_pkg::out_item_t                         result
);

	localparam int SW  = hrs_pkg::AVG_SUM_W;
	localparam int TW  = hrs_pkg::TAPS_W;
	localparam int MW  = SW + 14;
	// floor(s/3) = (s*2731)>>13 and floor(s/5) = (s*3277)>>14 for s up to 5*255
	localparam logic [MW-1:0] DIV3_MUL = MW'(2731);
	localparam logic [MW-1:0] DIV5_MUL = MW'(3277);

	function automatic hrs_pkg::sample_t div_taps(input logic [SW-1:0] s, input logic [TW-1:0] n);
		logic [MW-1:0] m3, m5;
		logic [SW-1:0] q;
		m3 = (MW'(s) * DIV3_MUL) >> 13;
		m5 = (MW'(s) * DIV5_MUL) >> 14;
		unique case (n)
			TW'(2):  q = s >> 1;
			TW'(3):  q = m3[SW-1:0];
			TW'(4):  q = s >> 2;
			TW'(5):  q = m5[SW-1:0];
			default: q = s;
		endcase
		return q[hrs_pkg::SAMPLE_W-1:0];
	endfunction

	hrs_pkg::tap_ctl_t  ctl_s6;
	logic               vld_s7;
	logic [SW-1:0]      sum_s7;
	logic [TW-1:0]      cnt_s7;
	logic               vld_s8;
	hrs_pkg::out_item_t res_s8;

	logic [SW-1:0] sum_d;
	logic [TW-1:0] cnt_d;

	// Masked sum of the enabled taps
	always_comb begin
		sum_d = SW'(rdata[hrs_pkg::TAP_C])
			+ (ctl_s6.use_up ? SW'(rdata[hrs_pkg::TAP_U]) : SW'(0))
			+ (ctl_s6.use_dn ? SW'(rdata[hrs_pkg::TAP_D]) : SW'(0))
			+ (ctl_s6.use_lf ? SW'(rdata[hrs_pkg::TAP_L]) : SW'(0))
			+ (ctl_s6.use_rt ? SW'(rdata[hrs_pkg::TAP_R]) : SW'(0));
		cnt_d = TW'(1) + TW'(ctl_s6.use_up) + TW'(ctl_s6.use_dn)
			+ TW'(ctl_s6.use_lf) + TW'(ctl_s6.use_rt);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			ctl_s6 <= ctl;
			vld_s7 <= ctl_s6.valid;
			vld_s8 <= vld_s7;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		sum_s7            <= sum_d;
		cnt_s7            <= cnt_d;
		res_s8.height_avg <= div_taps(sum_s7, cnt_s7);
		res_s8.taps_used  <= cnt_s7;
	end

	assign done   = vld_s8;
	assign result = res_s8;

endmodule
